// ===== src/edd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edd_pkg
// Shared sizes, register indexes and types of the error diffusion dither.
// ----------------------------------------------------------------------------
package edd_pkg;

    // Image and pixel sizes.
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int PIX_W     = 8;
    localparam int LW_W      = 11;

    // Error values: the raw error lies in -255..254 and every stored entry
    // stays well inside that span.
    localparam int ERR_W = PIX_W + 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = LW_W;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 1'd1;

    localparam logic [LW_W-1:0]  LW_RESET  = 11'd640;
    localparam logic [PIX_W-1:0] THR_RESET = 8'd128;

    typedef logic [COL_W-1:0]        t_col;
    typedef logic signed [ERR_W-1:0] t_err;

    // Position of one pixel, fixed when the pixel is taken in.
    typedef struct packed {
        t_col col;
        logic first_row;
        logic last;
        logic frame_start;
    } t_pos;

    // Write port of the line store.
    typedef struct packed {
        logic we;
        t_col addr;
        t_err data;
    } t_wr;

endpackage

// ===== src/edd_line_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edd_line_mem
// Line store of next-row errors: one write and one registered read per
// cycle, with write-to-read forwarding when both hit the same entry.
// ----------------------------------------------------------------------------
module edd_line_mem (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  edd_pkg::t_wr  i_wr,
    input  logic          i_rd_en,
    input  edd_pkg::t_col i_rd_addr,
    output edd_pkg::t_err o_rd_data
);
    import edd_pkg::*;

    t_err mem [MAX_WIDTH];
    t_err r_rd_data;
    t_err r_fwd_data;
    logic r_fwd;

    // Storage array with a synchronous read.
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data  <= mem[i_rd_addr];
            r_fwd_data <= i_wr.data;
        end
    end

    // A write to the entry being read in the same cycle wins over the array.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr.we && (i_wr.addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_rd_data;

endmodule

// ===== src/edd_col.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edd_col
// Column and row tracking at pixel intake: column count, first-row flag and
// end-of-row detection against the programmed line width.
// ----------------------------------------------------------------------------
module edd_col (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic                     i_frame_start,
    input  logic [edd_pkg::LW_W-1:0] i_line_width,
    output edd_pkg::t_pos            o_pos
);
    import edd_pkg::*;

    t_col r_col;
    t_col n_col;
    logic r_first;
    logic n_first;
    t_col last_col;

    // Last column index, with a zero width taken as one and an oversize
    // width taken as the store depth.
    always_comb begin
        if (i_line_width == '0) begin
            last_col = '0;
        end else if (i_line_width > LW_W'(MAX_WIDTH)) begin
            last_col = COL_W'(MAX_WIDTH - 1);
        end else begin
            last_col = COL_W'(i_line_width - LW_W'(1));
        end
    end

    // Position of the pixel offered now.
    always_comb begin
        o_pos.frame_start = i_frame_start;
        o_pos.col         = i_frame_start ? '0 : r_col;
        o_pos.first_row   = i_frame_start | r_first;
        o_pos.last        = o_pos.col >= last_col;
        n_col             = o_pos.last ? '0 : o_pos.col + COL_W'(1);
        n_first           = o_pos.last ? 1'b0 : o_pos.first_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_first <= 1'b1;
        end else if (i_accept) begin
            r_col   <= n_col;
            r_first <= n_first;
        end
    end

    // A row end restarts the column count and clears the first-row flag.
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_pos.last) |=> (r_col == '0 && !r_first))
        else $error("row end did not restart the column count");

endmodule

// ===== src/edd_diffuse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edd_diffuse
// Quantizer and error spreader: adds the incoming errors, clamps, compares
// with the threshold and splits the error into its four shares. Holds the
// right-hand share, the pending down-right share and the partial entry of
// the previous column until the next pixel completes it.
// ----------------------------------------------------------------------------
module edd_diffuse (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic [edd_pkg::PIX_W-1:0] i_gray,
    input  edd_pkg::t_pos             i_pos,
    input  edd_pkg::t_err             i_entry,
    input  logic [edd_pkg::PIX_W-1:0] i_threshold,
    output logic                      o_white,
    output edd_pkg::t_wr              o_wr
);
    import edd_pkg::*;

    localparam int SUM_W = PIX_W + 3;
    localparam int PRD_W = ERR_W + 4;

    localparam logic [2:0] K_RIGHT      = 3'd7;
    localparam logic [2:0] K_DOWN_LEFT  = 3'd3;
    localparam logic [2:0] K_DOWN       = 3'd5;
    localparam logic [2:0] K_DOWN_RIGHT = 3'd1;

    localparam logic signed [SUM_W-1:0] PIX_MAX = SUM_W'((1 << PIX_W) - 1);

    // Share of an error in sixteenths, rounded toward minus infinity.
    function automatic t_err f_share(input t_err e, input logic [2:0] k);
        logic signed [PRD_W-1:0] p;
        p = e * $signed({1'b0, k});
        return t_err'(p >>> 4);
    endfunction

    t_err r_rc;
    t_err r_dp;
    logic r_hold_valid;
    t_col r_hold_addr;
    t_err r_hold_data;

    t_err rc_use;
    t_err dp_use;
    t_err entry;
    logic signed [SUM_W-1:0] sum;
    logic [PIX_W-1:0] val;
    t_err err;
    t_err s_right;
    t_err s_down_left;
    t_err s_down;
    t_err s_down_right;

    // Sum, clamp and threshold.
    always_comb begin
        rc_use = i_pos.frame_start ? '0 : r_rc;
        dp_use = i_pos.frame_start ? '0 : r_dp;
        if (i_pos.first_row) begin
            entry = '0;
        end else if (r_hold_valid && r_hold_addr == i_pos.col) begin
            entry = r_hold_data;
        end else begin
            entry = i_entry;
        end
        sum = $signed({3'b000, i_gray}) + SUM_W'(rc_use) + SUM_W'(entry);
        if (sum < 0) begin
            val = '0;
        end else if (sum > PIX_MAX) begin
            val = '1;
        end else begin
            val = sum[PIX_W-1:0];
        end
        o_white = val >= i_threshold;
        if (o_white) begin
            err = $signed({1'b0, val}) - $signed({1'b0, {PIX_W{1'b1}}});
        end else begin
            err = $signed({1'b0, val});
        end
        s_right      = f_share(err, K_RIGHT);
        s_down_left  = f_share(err, K_DOWN_LEFT);
        s_down       = f_share(err, K_DOWN);
        s_down_right = f_share(err, K_DOWN_RIGHT);
    end

    // The previous column's entry is finished here: it gets the down-left
    // share unless this pixel opens a row.
    always_comb begin
        o_wr.we   = i_en && r_hold_valid;
        o_wr.addr = r_hold_addr;
        if (i_pos.col == '0) begin
            o_wr.data = r_hold_data;
        end else begin
            o_wr.data = r_hold_data + s_down_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc         <= '0;
            r_dp         <= '0;
            r_hold_valid <= 1'b0;
        end else if (i_en) begin
            r_rc         <= i_pos.last ? '0 : s_right;
            r_dp         <= i_pos.last ? '0 : s_down_right;
            r_hold_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hold_addr <= i_pos.col;
            r_hold_data <= dp_use + s_down;
        end
    end

    // Inside a row the held entry is always the column just to the left.
    a_hold_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_pos.col != '0) |->
            (r_hold_valid && r_hold_addr == i_pos.col - COL_W'(1)))
        else $error("held entry is not the left neighbor");

    // A frame start always falls at column zero of a first row.
    a_fs_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_pos.frame_start) |-> (i_pos.col == '0 && i_pos.first_row))
        else $error("frame start not at column zero of a first row");

endmodule

// ===== src/error_diffusion_dither.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// error_diffusion_dither
// Streaming Floyd-Steinberg dither of 8-bit gray pixels to 1-bit output.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter in raster order on i_valid / o_stall with i_gray and
//   i_frame_start; a beat is taken at a clock edge with i_valid high and
//   o_stall low. Each pixel gives one result beat on o_valid / i_stall,
//   carrying o_out_white and o_row_end, in input order.
//   Line width and threshold are set through the write port (i_cfg_we,
//   i_cfg_index, i_cfg_data) while no pixel is in flight.
//   A taken pixel goes through the intake stage and then the result register.
//   Throughput: one pixel per cycle unless the receiver stalls. The store
//   is read for column x when that pixel is taken and written with the
//   finished entry of column x-1 as that pixel is computed; one port pair suffices.
//   Reset sets width 640, threshold 128 and clears the pipeline and carries;
//   the line store keeps no reset, and the first row of every image skips it.
//   When the receiver stalls, the result register holds its beat, one more
//   pixel waits in the intake stage, and o_stall then rises.
// ----------------------------------------------------------------------------
module error_diffusion_dither (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [edd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [edd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [edd_pkg::PIX_W-1:0]      i_gray,
    input  logic                           i_frame_start,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_out_white,
    output logic                           o_row_end
);
    import edd_pkg::*;

    logic [LW_W-1:0]  r_line_width;
    logic [PIX_W-1:0] r_threshold;

    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_gray;
    t_pos             r_s1_pos;

    logic             r_o_valid;
    logic             r_out_white;
    logic             r_row_end;

    logic accept;
    logic s1_adv;
    t_pos pos;
    t_err entry;
    t_wr  wr;
    logic white;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LW_RESET;
            r_threshold  <= THR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LINE_WIDTH: r_line_width <= i_cfg_data;
                CFG_THRESHOLD:  r_threshold  <= i_cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: the compute stage moves on whenever the result register
    // is empty or being emptied.
    assign s1_adv  = r_s1_valid && (!r_o_valid || !i_stall);
    assign o_stall = r_s1_valid && r_o_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    edd_col u_col (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_frame_start (i_frame_start),
        .i_line_width  (r_line_width),
        .o_pos         (pos)
    );

    edd_line_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_rd_en   (accept),
        .i_rd_addr (pos.col),
        .o_rd_data (entry)
    );

    // Intake stage: pixel and position wait here for the store read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_gray <= i_gray;
            r_s1_pos  <= pos;
        end
    end

    edd_diffuse u_diffuse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (s1_adv),
        .i_gray      (r_s1_gray),
        .i_pos       (r_s1_pos),
        .i_entry     (entry),
        .i_threshold (r_threshold),
        .o_white     (white),
        .o_wr        (wr)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_white <= white;
            r_row_end   <= r_s1_pos.last;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_out_white = r_out_white;
    assign o_row_end   = r_row_end;

    // Every beat taken in reaches the intake stage.
    a_accept_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted pixel missing from intake stage");

    // Every pixel leaving the compute stage lands in the result register.
    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_o_valid)
        else $error("computed pixel missing from result register");

    // The store is written only while a pixel is being computed.
    a_wr_en: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.we |-> s1_adv)
        else $error("line store written without a pixel in flight");

endmodule

// ===== test/error_diffusion_dither_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// error_diffusion_dither_tb
// Self-checking bench for the streaming Floyd-Steinberg dither.
// ----------------------------------------------------------------------------
// A bit-exact software tracker predicts every dithered pixel and its row-end
// flag from the gray values that the block accepts. Short handwritten rows
// probe the threshold boundary, the clamps, a frame start in mid-row and a
// width lowered in mid-row. Random images follow over several width and
// threshold settings, among them the clamped widths 0 and 2047. Both sides
// idle and stall at random, with one stretch at full rate.
// ----------------------------------------------------------------------------
module error_diffusion_dither_tb;

    import edd_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PIX_MAX     = 255;

    // One predicted result beat.
    typedef struct packed {
        logic white;
        logic row_end;
    } t_dot;

    // Tracks the dither state and holds the predicted beats in order.
    class dither_tracker;
        logic [LW_W-1:0]  width_reg;
        logic [PIX_W-1:0] thresh_reg;
        int               row_err [MAX_WIDTH];
        bit               written [MAX_WIDTH];
        int               carry_right;
        int               carry_diag;
        int               col;
        bit               top_row;
        t_dot             due_dots [$];
        int               checked;
        int               mismatches;

        function new();
            width_reg   = LW_RESET;
            thresh_reg  = THR_RESET;
            carry_right = 0;
            carry_diag  = 0;
            col         = 0;
            top_row     = 1'b1;
            checked     = 0;
            mismatches  = 0;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_LINE_WIDTH)
                width_reg = data;
            else if (idx == CFG_THRESHOLD)
                thresh_reg = data[PIX_W-1:0];
        endfunction

        // Floor of err * k / 16.
        function int share16(int err, int k);
            return (err * k) >>> 4;
        endfunction

        function int cur_col();
            return (col >= MAX_WIDTH) ? MAX_WIDTH - 1 : col;
        endfunction

        // True when the next pixel, without a frame start, would read a
        // line store entry that was never written.
        function bit reads_unwritten();
            return !top_row && !written[cur_col()];
        endfunction

        function bit at_row_start();
            return col == 0;
        endfunction

        function int pending();
            return due_dots.size();
        endfunction

        function void predict_pixel(logic [PIX_W-1:0] gray, logic fs);
            int   w;
            int   x;
            int   v;
            int   err;
            bit   last;
            bit   white;
            t_dot d;
            w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
            if (fs) begin
                col         = 0;
                carry_right = 0;
                carry_diag  = 0;
                top_row     = 1'b1;
            end
            x    = cur_col();
            last = x >= w - 1;

            // Incoming error is clamped once on arrival.
            v = int'(gray) + carry_right;
            if (!top_row)
                v += row_err[x];
            if (v > PIX_MAX)
                v = PIX_MAX;
            if (v < 0)
                v = 0;
            white = v >= int'(thresh_reg);
            err   = white ? v - PIX_MAX : v;

            // Down-left share is dropped at the left edge.
            if (x > 0)
                row_err[x-1] = row_err[x-1] + share16(err, 3);
            row_err[x] = carry_diag + share16(err, 5);
            written[x] = 1'b1;

            if (last) begin
                carry_right = 0;
                carry_diag  = 0;
                col         = 0;
                top_row     = 1'b0;
            end else begin
                carry_right = share16(err, 7);
                carry_diag  = share16(err, 1);
                col         = x + 1;
            end

            d.white   = white;
            d.row_end = last;
            due_dots.push_back(d);
        endfunction

        function void check_dot(logic white, logic row_end);
            t_dot d;
            if (due_dots.size() == 0) begin
                $error("unexpected result beat: out_white %0b row_end %0b", white, row_end);
                mismatches++;
                return;
            end
            d = due_dots.pop_front();
            checked++;
            if (white !== d.white) begin
                $error("out_white: expected %0b, actual %0b", d.white, white);
                mismatches++;
            end
            if (row_end !== d.row_end) begin
                $error("row_end: expected %0b, actual %0b", d.row_end, row_end);
                mismatches++;
            end
        endfunction

        function void close_out();
            if (due_dots.size() != 0) begin
                $error("%0d expected result beats never arrived", due_dots.size());
                mismatches += due_dots.size();
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = CFG_LINE_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  i_valid       = 1'b0;
    logic                  o_stall;
    logic [PIX_W-1:0]      i_gray        = '0;
    logic                  i_frame_start = 1'b0;
    logic                  o_valid;
    logic                  i_stall       = 1'b0;
    logic                  o_out_white;
    logic                  o_row_end;

    dither_tracker tracker;
    bit            quiet       = 1'b0;
    int            sent        = 0;
    int            idle_cycles = 0;

    error_diffusion_dither dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_gray        (i_gray),
        .i_frame_start (i_frame_start),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_white   (o_out_white),
        .o_row_end     (o_row_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Result side: check each accepted beat and stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                tracker.check_dot(o_out_white, o_row_end);
            i_stall <= !quiet && ($urandom_range(99) < 14);
        end
    end

    // Watchdog on cycles with no beat taken on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Present one pixel beat, after an optional random gap, until taken.
    task automatic push_pixel(input logic [PIX_W-1:0] gray, input logic fs);
        if (!quiet) begin
            while ($urandom_range(99) < 14) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid       <= 1'b1;
        i_gray        <= gray;
        i_frame_start <= fs;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        tracker.predict_pixel(gray, fs);
        sent++;
    endtask

    // Stop sending and let every predicted beat come out.
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        tracker.set_config(idx, data);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Handwritten rows at width 4: boundary values, a frame start in
    // mid-row and a width lowered while a row is open.
    task automatic directed_rows();
        wait_idle();
        set_register(CFG_LINE_WIDTH, 11'd4);
        set_register(CFG_THRESHOLD, 11'd128);
        push_pixel(8'd255, 1'b1);
        push_pixel(8'd0,   1'b0);
        push_pixel(8'd128, 1'b0);
        push_pixel(8'd127, 1'b0);
        push_pixel(8'd255, 1'b0);
        push_pixel(8'd0,   1'b0);
        push_pixel(8'd255, 1'b0);
        push_pixel(8'd0,   1'b0);
        push_pixel(8'd129, 1'b0);
        push_pixel(8'd1,   1'b0);
        push_pixel(8'd254, 1'b1);
        push_pixel(8'd100, 1'b0);
        push_pixel(8'd200, 1'b0);
        push_pixel(8'd50,  1'b0);
        push_pixel(8'd77,  1'b0);
        push_pixel(8'd180, 1'b0);
        push_pixel(8'd90,  1'b0);
        // Column 3 is next; width 2 makes the coming pixel end the row.
        wait_idle();
        set_register(CFG_LINE_WIDTH, 11'd2);
        push_pixel(8'd60,  1'b0);
        push_pixel(8'd128, 1'b0);
        push_pixel(8'd127, 1'b0);
    endtask

    // Random images at one setting; frame starts mostly fall at row starts.
    task automatic run_stream(input logic [CFG_DATA_W-1:0] width,
                              input logic [CFG_DATA_W-1:0] thr_word,
                              input int count, input bit pause_mid);
        int               k;
        int               pick;
        int               t;
        logic [PIX_W-1:0] g;
        logic             fs;
        wait_idle();
        set_register(CFG_LINE_WIDTH, width);
        set_register(CFG_THRESHOLD, thr_word);
        for (k = 0; k < count; k++) begin
            if (pause_mid && k == count / 2)
                wait_idle();
            fs = (k == 0) || tracker.reads_unwritten()
                 || (tracker.at_row_start() && $urandom_range(99) < 15)
                 || ($urandom_range(99) < 2);
            pick = $urandom_range(9);
            if (pick < 4) begin
                g = 8'($urandom_range(255));
            end else if (pick < 6) begin
                g = $urandom_range(1) ? 8'd255 : 8'd0;
            end else if (pick < 8) begin
                t = int'(thr_word[PIX_W-1:0]) + $urandom_range(6) - 3;
                g = (t < 0) ? 8'd0 : (t > PIX_MAX) ? 8'd255 : 8'(t);
            end else begin
                g = 8'(1 << $urandom_range(7));
                if ($urandom_range(1))
                    g = ~g;
            end
            push_pixel(g, fs);
        end
    endtask

    initial begin
        tracker = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_rows();

        // Width 0 counts as one pixel per row.
        run_stream(11'd0, 11'd255, 30, 1'b0);
        run_stream(11'd1, 11'd0, 30, 1'b0);
        // Upper data bits are ignored by the threshold register.
        run_stream(11'd5, 11'h7FF, 40, 1'b0);
        quiet = 1'b1;
        run_stream(11'd7, 11'd100, 100, 1'b0);
        quiet = 1'b0;
        // Width 2047 counts as the full line store; one row and a bit more.
        run_stream(11'd2047, 11'd128, 1030, 1'b0);
        run_stream(11'd3, 11'($urandom_range(255)), 40, 1'b1);
        run_stream(11'($urandom_range(16, 40)), 11'($urandom_range(255)), 40, 1'b0);

        wait_idle();
        tracker.close_out();
        $display("summary: %0d pixels sent, %0d result beats checked, %0d mismatches",
                 sent, tracker.checked, tracker.mismatches);
        $display("summary: widths 0 to 2047 incl. clamps, thresholds 0 to 255, mid-row cases");
        if (tracker.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
